### src/mtfl_pkg.sv
// ----------------------------------------------------------------------------
// mtfl_pkg
// Shared types, codes and defaults for the move-to-front ordered list.
// ----------------------------------------------------------------------------
package mtfl_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int LABEL_CHARS_DEF = 7;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int IN_LBL_W = 56;
  localparam int MAX_LBL_W = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_INS_AFTER  = 3'd4,
    OP_FIND       = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef enum logic [2:0] {
    ACT_HOLD  = 3'd0,
    ACT_LEFT  = 3'd1,
    ACT_RIGHT = 3'd2,
    ACT_NEW   = 3'd3,
    ACT_FOUND = 3'd4
  } act_e;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] match_value;
    logic signed [VALUE_W-1:0] new_value;
    logic [IN_LBL_W-1:0]       new_label;
    logic                      move_to_front;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  compares_made;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] match_value;
    logic signed [VALUE_W-1:0] new_value;
    logic                      move_to_front;
    logic                      full;
    logic                      found;
    logic                      commit;
  } cell_cmd_t;

endpackage

### src/mtfl_cell.sv
// ----------------------------------------------------------------------------
// mtfl_cell
// One list slot: holds an entry, compares it, and picks its next entry from
// itself, a neighbor, the new entry or the found entry.
// ----------------------------------------------------------------------------
module mtfl_cell #(
  parameter int IDX     = 0,
  parameter int CNT_W   = 5,
  parameter int LABEL_W = 56
) (
  input  logic                             clk_i,
  input  mtfl_pkg::cell_cmd_t              cmd_i,
  input  logic [CNT_W-1:0]                 len_i,
  input  logic [LABEL_W-1:0]               new_label_i,
  input  logic [LABEL_W-1:0]               found_label_i,
  input  logic signed [mtfl_pkg::VALUE_W-1:0] left_value_i,
  input  logic [LABEL_W-1:0]               left_label_i,
  input  logic signed [mtfl_pkg::VALUE_W-1:0] right_value_i,
  input  logic [LABEL_W-1:0]               right_label_i,
  input  logic                             seen_i,
  input  logic                             left_first_i,
  output logic signed [mtfl_pkg::VALUE_W-1:0] value_o,
  output logic [LABEL_W-1:0]               label_o,
  output logic                             seen_o,
  output logic                             first_o
);
  import mtfl_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam bit IS_HEAD = (IDX == 0);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [LABEL_W-1:0]        label_q, label_d;
  logic                      occ, hit;
  act_e                      act;

  assign occ     = (IDX_C < len_i);
  assign hit     = occ && (value_q == cmd_i.match_value);
  assign first_o = hit && !seen_i;
  assign seen_o  = seen_i || hit;

  always_comb begin
    act = ACT_HOLD;
    case (cmd_i.op)
      OP_APPEND: begin
        if (!cmd_i.full && (IDX_C == len_i)) act = ACT_NEW;
      end
      OP_PREPEND: begin
        if (!cmd_i.full) begin
          if (IS_HEAD) act = ACT_NEW;
          else if (IDX_C <= len_i) act = ACT_LEFT;
        end
      end
      OP_REMOVE: begin
        if (cmd_i.found && seen_o) act = ACT_RIGHT;
      end
      OP_INS_BEFORE: begin
        if (cmd_i.found && !cmd_i.full) begin
          if (first_o) act = ACT_NEW;
          else if (seen_i) act = ACT_LEFT;
        end
      end
      OP_INS_AFTER: begin
        if (cmd_i.found && !cmd_i.full) begin
          if (left_first_i) act = ACT_NEW;
          else if (seen_i) act = ACT_LEFT;
        end
      end
      OP_FIND: begin
        if (cmd_i.found && cmd_i.move_to_front) begin
          if (IS_HEAD) act = ACT_FOUND;
          else if (!seen_i) act = ACT_LEFT;
        end
      end
      default: act = ACT_HOLD;
    endcase
  end

  always_comb begin
    value_d = value_q;
    label_d = label_q;
    if (cmd_i.commit) begin
      case (act)
        ACT_LEFT: begin
          value_d = left_value_i;
          label_d = left_label_i;
        end
        ACT_RIGHT: begin
          value_d = right_value_i;
          label_d = right_label_i;
        end
        ACT_NEW: begin
          value_d = cmd_i.new_value;
          label_d = new_label_i;
        end
        ACT_FOUND: begin
          value_d = cmd_i.match_value;
          label_d = found_label_i;
        end
        default: begin
          value_d = value_q;
          label_d = label_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    label_q <= label_d;
  end

  assign value_o = value_q;
  assign label_o = label_q;

endmodule

### src/move_to_front_ordered_list.sv
// ----------------------------------------------------------------------------
// move_to_front_ordered_list
// Ordered list of signed values with labels, kept in a row of cells, with
// append, prepend, remove, insert before/after and find with move to front.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// For each item, the accept edge latches the command, and the commit edge
// runs the compares in every cell, resolves the first match along the
// cell chain, shifts the row and loads the result register.
// The result register holds a result while out_stall_i is high; the command
// then waits in place and no new item is taken until it is written out.
// Reset empties the list at once (length zero); entry contents are not
// cleared and are never read past the length.
//
module move_to_front_ordered_list #(
  parameter int CAPACITY    = mtfl_pkg::CAPACITY_DEF,
  parameter int LABEL_CHARS = mtfl_pkg::LABEL_CHARS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtfl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtfl_pkg::out_item_t out_item_o
);
  import mtfl_pkg::*;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int LABEL_W = 8 * LABEL_CHARS;

  // Control
  fsm_e      state_q, state_d;
  logic      accept, commit;
  in_item_t  cmd_q;
  logic [CNT_W-1:0] len_q, len_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // Cell row
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic [LABEL_W-1:0]        cell_label [CAPACITY];
  logic [CAPACITY:0]         seen;
  logic [CAPACITY-1:0]       first;
  cell_cmd_t                 cell_cmd;
  logic [MAX_LBL_W-1:0]      label_ext;
  logic [LABEL_W-1:0]        new_label;
  logic [LABEL_W-1:0]        found_label;
  logic [CNT_W-1:0]          match_pos1;
  logic                      full, found;
  logic [31:0]               len_wide, pos_wide;

  // ---- Handshake and sequencing -------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (accept) state_d = FSM_EXEC;
      FSM_EXEC: if (commit) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != FSM_IDLE);
    commit     = (state_q == FSM_EXEC) && (!out_valid_q || !out_stall_i);
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the command on accept, the result on commit.
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= in_item_i;
    if (commit) out_q <= out_d;
  end

  assign out_valid_d = commit ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---- Broadcast to the cells ---------------------------------------------
  assign full      = (len_q >= CNT_W'(CAPACITY));
  assign found     = seen[CAPACITY];
  assign label_ext = MAX_LBL_W'(cmd_q.new_label);
  assign new_label = label_ext[LABEL_W-1:0];

  always_comb begin
    cell_cmd.op            = cmd_q.operation;
    cell_cmd.match_value   = cmd_q.match_value;
    cell_cmd.new_value     = cmd_q.new_value;
    cell_cmd.move_to_front = cmd_q.move_to_front;
    cell_cmd.full          = full;
    cell_cmd.found         = found;
    cell_cmd.commit        = commit;
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value, right_value;
    logic [LABEL_W-1:0]        left_label, right_label;
    logic                      left_first;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_label = '0;
      assign left_first = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_label = cell_label[i-1];
      assign left_first = first[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
      assign right_label = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_label = cell_label[i+1];
    end

    mtfl_cell #(
      .IDX     (i),
      .CNT_W   (CNT_W),
      .LABEL_W (LABEL_W)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cell_cmd),
      .len_i         (len_q),
      .new_label_i   (new_label),
      .found_label_i (found_label),
      .left_value_i  (left_value),
      .left_label_i  (left_label),
      .right_value_i (right_value),
      .right_label_i (right_label),
      .seen_i        (seen[i]),
      .left_first_i  (left_first),
      .value_o       (cell_value[i]),
      .label_o       (cell_label[i]),
      .seen_o        (seen[i+1]),
      .first_o       (first[i])
    );
  end

  // Pick the label and position of the first match (one-hot select).
  always_comb begin
    found_label = '0;
    match_pos1  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        found_label = found_label | cell_label[i];
        match_pos1  = match_pos1 | CNT_W'(i + 1);
      end
    end
  end

  // ---- Status, compare count and new length -------------------------------
  always_comb begin
    out_d.status        = STAT_DONE;
    out_d.compares_made = '0;
    len_d               = len_q;
    pos_wide            = 32'(match_pos1);
    case (cmd_q.operation)
      OP_APPEND, OP_PREPEND: begin
        if (full) out_d.status = STAT_FULL;
        else len_d = len_q + CNT_W'(1);
      end
      OP_REMOVE: begin
        if (!found) out_d.status = STAT_NOT_FOUND;
        else len_d = len_q - CNT_W'(1);
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (!found) out_d.status = STAT_NOT_FOUND;
        else if (full) out_d.status = STAT_FULL;
        else len_d = len_q + CNT_W'(1);
      end
      OP_FIND: begin
        if (!found) out_d.status = STAT_NOT_FOUND;
        else out_d.compares_made = pos_wide[COUNT_W-1:0];
      end
      default: out_d.status = STAT_DONE;
    endcase
    if (!commit) len_d = len_q;
    len_wide          = 32'(len_d);
    out_d.entry_count = len_wide[COUNT_W-1:0];
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_len_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(len_q))
    else $error("list length changed without a committed item");

  a_count_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_q.entry_count == COUNT_W'(len_q)))
    else $error("reported entry count differs from list length");

  a_full_means_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (out_d.status == STAT_FULL) |=> (len_q == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_compares_only_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (cmd_q.operation != OP_FIND) |=> (out_q.compares_made == '0))
    else $error("compare count reported for an operation other than find");
`endif

endmodule
